// ===== sv/sfsds_pkg.sv =====
// Shared types and constants for the swap free-space device splitter.
// No dependencies; imported by the top level.
package sfsds_pkg;

	localparam int MAX_DEVICES = 8;
	localparam int DEV_W       = $clog2(MAX_DEVICES);
	localparam int CNT_W       = $clog2(MAX_DEVICES + 1);
	// divider dividend: region ends and boundary searches reach 2^33
	localparam int DIV_W       = 33;
	localparam int DIVC_W      = $clog2(DIV_W);
	localparam int TOP_W       = 32 + DEV_W;
	localparam int PADDR_W     = 4;

	typedef enum logic [1:0] {
		CMD_SET_SIZE = 2'd0,
		CMD_CLEAR    = 2'd1,
		CMD_ADD      = 2'd2,
		CMD_READ     = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_CHUNK_SIZE  = 2'd0,
		REG_INTLV_LIMIT = 2'd1,
		REG_INTLV_DEVS  = 2'd2,
		REG_DEV_TOTAL   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [2:0]  device;
		logic [31:0] start_block;
		logic [31:0] amount;
	} item_t;

	typedef struct packed {
		logic [31:0] device_free;
		logic [31:0] total_free;
	} result_t;

endpackage

// ===== sv/sfsds_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module sfsds_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/swap_free_space_device_split.sv =====
// Swap free-space device splitter: credits free block regions to swap devices.
// Depends on sfsds_pkg and sfsds_ram (device size and free count memories).
//
//   channel  | dir | handshake                  | beat
//   ---------+-----+----------------------------+-------------------------------
//   item     | in  | item_valid / item_stall    | cmd, device, start_block, amount
//   result   | out | result_valid / result_stall| device_free, total_free
//   config   | in  | APB psel/penable/pwrite    | four registers at 4*index
//
// Size write and clear go straight to ST_OUT, a count read through ST_RD. An add runs
// up to five passes of the shared restoring divider, the ST_LANE_B, ST_LANE_S and
// ST_LANE_W states for each interleaved device and, past the interleaved area, a walk
// over the sequential devices in which each but the last may take one more divider pass.
// Reset clears the counters (per-entry valid bits) and the sum, and sets the registers to defaults.
// item_stall is high whenever a command is in progress; a finished beat waits in
// the result register, and the next item is taken while it is stalled.
module swap_free_space_device_split (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [sfsds_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  sfsds_pkg::item_t               item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output sfsds_pkg::result_t             result
);
	import sfsds_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RD,
		ST_LIM_DIV,
		ST_S_DIV,
		ST_QS_DIV,
		ST_B_DIV,
		ST_QB_DIV,
		ST_LANE_B,
		ST_LANE_S,
		ST_LANE_W,
		ST_SEQ_INIT,
		ST_SEQ_DEV,
		ST_SEQ_TOP,
		ST_SEQ_G,
		ST_TOP_DIV,
		ST_SEQ_CNT,
		ST_CNT_WR,
		ST_OUT
	} state_t;

	// configuration registers
	logic [15:0] chunk_q;
	logic [31:0] lim_q;
	logic [3:0]  idevs_q;
	logic [3:0]  dtotal_q;

	state_t             state_q;
	logic [MAX_DEVICES-1:0] cnt_vld_q;
	logic [31:0]        free_sum_q;
	logic [31:0]        res_dev_q;
	logic               result_valid_q;
	result_t            result_q;

	logic [31:0]        s_q;
	logic [32:0]        e_q;
	logic [31:0]        b_q;
	logic [31:0]        qsn_q, qbn_q;
	logic [15:0]        rs_q, rb_q;
	logic [DEV_W-1:0]   ms_q, mb_q;
	logic [DEV_W-1:0]   lane_q;
	logic [31:0]        lb_q;
	logic [31:0]        delta_q;
	logic [DEV_W-1:0]   dev_w_q;
	logic [DEV_W-1:0]   cidx_q;
	logic               last_q;
	logic               rd_ok_q;
	logic [32:0]        prev_q;
	logic [32:0]        g_q;
	logic [TOP_W-1:0]   top_q;

	logic [DIV_W-1:0]   div_quo_q;
	logic [15:0]        div_rem_q;
	logic [15:0]        div_dsr_q;
	logic [DIVC_W-1:0]  div_cnt_q;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q  <= 16'd512;
			lim_q    <= '0;
			idevs_q  <= 4'd1;
			dtotal_q <= 4'd1;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_CHUNK_SIZE:  chunk_q  <= pwdata[15:0];
				REG_INTLV_LIMIT: lim_q    <= pwdata;
				REG_INTLV_DEVS:  idevs_q  <= pwdata[3:0];
				REG_DEV_TOTAL:   dtotal_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_CHUNK_SIZE:  prdata = {16'd0, chunk_q};
			REG_INTLV_LIMIT: prdata = lim_q;
			REG_INTLV_DEVS:  prdata = {28'd0, idevs_q};
			REG_DEV_TOTAL:   prdata = {28'd0, dtotal_q};
			default:         prdata = '0;
		endcase
	end

	// ---------------- derived configuration ----------------
	logic [7:0]       dt_w, id_w, nd_w, ni_w;
	logic [CNT_W-1:0] nd_c, ni_c;
	logic [DEV_W-1:0] nd_last;
	logic [15:0]      d_c;

	always_comb begin
		dt_w = {4'd0, dtotal_q};
		id_w = {4'd0, idevs_q};
		if (dt_w == 8'd0)
			nd_w = 8'd1;
		else if (dt_w > 8'(MAX_DEVICES))
			nd_w = 8'(MAX_DEVICES);
		else
			nd_w = dt_w;
		if (id_w == 8'd0)
			ni_w = 8'd1;
		else if (id_w > nd_w)
			ni_w = nd_w;
		else
			ni_w = id_w;
		nd_c    = CNT_W'(nd_w);
		ni_c    = CNT_W'(ni_w);
		nd_last = DEV_W'(nd_w - 8'd1);
		d_c     = (chunk_q == 16'd0) ? 16'd1 : chunk_q;
	end

	// ---------------- input decode ----------------
	logic             dev_ok;
	logic [DEV_W-1:0] dev_idx;
	logic [32:0]      e_in;

	assign dev_ok  = ({29'd0, item.device} < 32'(MAX_DEVICES));
	assign dev_idx = DEV_W'(item.device);
	assign e_in    = {1'b0, item.start_block} + {1'b0, item.amount};

	// ---------------- shared restoring divider, one quotient bit a cycle ----------------
	logic [16:0]      div_sh, div_sub;
	logic             div_ge;
	logic [15:0]      div_rem_nx;
	logic [DIV_W-1:0] div_quo_nx;
	logic             div_run, div_last;

	always_comb begin
		div_sh     = {div_rem_q, div_quo_q[DIV_W-1]};
		div_ge     = (div_sh >= {1'b0, div_dsr_q});
		div_sub    = div_sh - {1'b0, div_dsr_q};
		div_rem_nx = div_ge ? div_sub[15:0] : div_sh[15:0];
		div_quo_nx = {div_quo_q[DIV_W-2:0], div_ge};
		div_run    = (state_q == ST_LIM_DIV) || (state_q == ST_S_DIV) ||
		             (state_q == ST_QS_DIV) || (state_q == ST_B_DIV) ||
		             (state_q == ST_QB_DIV) || (state_q == ST_TOP_DIV);
		div_last   = (div_cnt_q == '0);
	end

	// ---------------- datapath helpers ----------------
	logic [31:0] lim_m, b_lim;
	logic [33:0] top_c;
	logic [32:0] top_g;
	logic        lane_sel_b, lane_last, seq_last;
	logic [31:0] lane_q_part, lane_full, lane_term;
	logic [15:0] lane_r;
	logic [DEV_W-1:0] lane_m;
	logic [47:0] lane_prod;

	always_comb begin
		// interleave boundary: limit rounded down to a chunk start
		lim_m = lim_q - {16'd0, div_rem_nx};
		b_lim = (lim_m > s_q) ? lim_m : s_q;
		// next chunk start at or above the device top, capped at the region end
		top_c = {1'b0, top_q[DIV_W-1:0]} +
		        ((div_rem_nx == 16'd0) ? 34'd0 : 34'(d_c - div_rem_nx));
		top_g = (top_c < {1'b0, e_q}) ? top_c[32:0] : e_q;

		// blocks of [0,x) on lane k: (x/d/n + (x/d%n > k))*d + (x/d%n == k ? x%d : 0)
		lane_sel_b  = (state_q == ST_LANE_B);
		lane_q_part = lane_sel_b ? qbn_q : qsn_q;
		lane_m      = lane_sel_b ? mb_q : ms_q;
		lane_r      = lane_sel_b ? rb_q : rs_q;
		lane_full   = lane_q_part + ((lane_m > lane_q) ? 32'd1 : 32'd0);
		lane_prod   = lane_full * d_c;
		lane_term   = lane_prod[31:0] + ((lane_m == lane_q) ? {16'd0, lane_r} : 32'd0);
		lane_last   = (CNT_W'(lane_q) + CNT_W'(1) == ni_c);
		seq_last    = (CNT_W'(dev_w_q) >= nd_c - CNT_W'(1));
	end

	// ---------------- memories ----------------
	logic             size_we, size_re;
	logic [DEV_W-1:0] size_waddr, size_raddr;
	logic [31:0]      size_rdata;
	logic             cnt_we, cnt_re;
	logic [DEV_W-1:0] cnt_waddr, cnt_raddr;
	logic [31:0]      cnt_wdata, cnt_rdata;

	always_comb begin
		size_we    = (state_q == ST_IDLE) && item_valid && (item.cmd == CMD_SET_SIZE) && dev_ok;
		size_waddr = dev_idx;
		size_re    = (state_q == ST_SEQ_DEV) && !seq_last;
		size_raddr = dev_w_q;

		cnt_re    = 1'b0;
		cnt_raddr = dev_w_q;
		unique case (state_q)
			ST_IDLE: begin
				cnt_re    = item_valid && (item.cmd == CMD_READ);
				cnt_raddr = dev_idx;
			end
			ST_LANE_B: begin
				cnt_re    = 1'b1;
				cnt_raddr = lane_q;
			end
			ST_SEQ_DEV: begin
				cnt_re    = seq_last;
				cnt_raddr = nd_last;
			end
			ST_SEQ_CNT: begin
				cnt_re    = 1'b1;
				cnt_raddr = dev_w_q;
			end
			default: ;
		endcase

		cnt_we    = (state_q == ST_LANE_W) || (state_q == ST_CNT_WR);
		cnt_waddr = (state_q == ST_LANE_W) ? lane_q : cidx_q;
		// a never-written or cleared entry reads as zero
		cnt_wdata = (cnt_vld_q[cnt_waddr] ? cnt_rdata : 32'd0) + delta_q;
	end

	sfsds_ram #(.WIDTH(32), .DEPTH(MAX_DEVICES)) u_size_ram (
		.clk   (clk),
		.we    (size_we),
		.waddr (size_waddr),
		.wdata (item.amount),
		.re    (size_re),
		.raddr (size_raddr),
		.rdata (size_rdata)
	);

	sfsds_ram #(.WIDTH(32), .DEPTH(MAX_DEVICES)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (cnt_re),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	// ---------------- control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_vld_q      <= '0;
			free_sum_q     <= '0;
			res_dev_q      <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
			s_q            <= '0;
			e_q            <= '0;
			b_q            <= '0;
			qsn_q          <= '0;
			qbn_q          <= '0;
			rs_q           <= '0;
			rb_q           <= '0;
			ms_q           <= '0;
			mb_q           <= '0;
			lane_q         <= '0;
			lb_q           <= '0;
			delta_q        <= '0;
			dev_w_q        <= '0;
			cidx_q         <= '0;
			last_q         <= 1'b0;
			rd_ok_q        <= 1'b0;
			prev_q         <= '0;
			g_q            <= '0;
			top_q          <= '0;
			div_quo_q      <= '0;
			div_rem_q      <= '0;
			div_dsr_q      <= '0;
			div_cnt_q      <= '0;
		end else begin
			// in ST_OUT the result register is loaded or kept by the state logic
			if (result_valid_q && !result_stall && state_q != ST_OUT) begin
				result_valid_q <= 1'b0;
			end
			// the last step is taken by the state that consumes the quotient
			if (div_run && !div_last) begin
				div_quo_q <= div_quo_nx;
				div_rem_q <= div_rem_nx;
				div_cnt_q <= div_cnt_q - DIVC_W'(1);
			end

			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						res_dev_q <= '0;
						unique case (item.cmd)
							CMD_SET_SIZE: state_q <= ST_OUT;
							CMD_CLEAR: begin
								cnt_vld_q  <= '0;
								free_sum_q <= '0;
								state_q    <= ST_OUT;
							end
							CMD_READ: begin
								cidx_q  <= dev_idx;
								rd_ok_q <= dev_ok;
								state_q <= ST_RD;
							end
							CMD_ADD: begin
								free_sum_q <= free_sum_q + item.amount;
								s_q        <= item.start_block;
								e_q        <= e_in;
								div_rem_q  <= '0;
								div_dsr_q  <= d_c;
								div_cnt_q  <= DIVC_W'(DIV_W - 1);
								if (item.amount == 32'd0) begin
									state_q <= ST_OUT;
								end else if (e_in <= {1'b0, lim_q}) begin
									// whole region is interleaved
									b_q       <= e_in[31:0];
									div_quo_q <= DIV_W'(item.start_block);
									state_q   <= ST_S_DIV;
								end else begin
									div_quo_q <= DIV_W'(lim_q);
									state_q   <= ST_LIM_DIV;
								end
							end
						endcase
					end
				end

				ST_RD: begin
					res_dev_q <= (rd_ok_q && cnt_vld_q[cidx_q]) ? cnt_rdata : 32'd0;
					state_q   <= ST_OUT;
				end

				ST_LIM_DIV: begin
					if (div_last) begin
						b_q <= b_lim;
						if (b_lim > s_q) begin
							div_rem_q <= '0;
							div_dsr_q <= d_c;
							div_cnt_q <= DIVC_W'(DIV_W - 1);
							div_quo_q <= DIV_W'(s_q);
							state_q   <= ST_S_DIV;
						end else begin
							state_q <= ST_SEQ_INIT;
						end
					end
				end

				ST_S_DIV: begin
					if (div_last) begin
						rs_q      <= div_rem_nx;
						div_quo_q <= DIV_W'(div_quo_nx[31:0]);
						div_rem_q <= '0;
						div_dsr_q <= 16'(ni_c);
						div_cnt_q <= DIVC_W'(DIV_W - 1);
						state_q   <= ST_QS_DIV;
					end
				end

				ST_QS_DIV: begin
					if (div_last) begin
						qsn_q     <= div_quo_nx[31:0];
						ms_q      <= DEV_W'(div_rem_nx);
						div_quo_q <= DIV_W'(b_q);
						div_rem_q <= '0;
						div_dsr_q <= d_c;
						div_cnt_q <= DIVC_W'(DIV_W - 1);
						state_q   <= ST_B_DIV;
					end
				end

				ST_B_DIV: begin
					if (div_last) begin
						rb_q      <= div_rem_nx;
						div_quo_q <= DIV_W'(div_quo_nx[31:0]);
						div_rem_q <= '0;
						div_dsr_q <= 16'(ni_c);
						div_cnt_q <= DIVC_W'(DIV_W - 1);
						state_q   <= ST_QB_DIV;
					end
				end

				ST_QB_DIV: begin
					if (div_last) begin
						qbn_q   <= div_quo_nx[31:0];
						mb_q    <= DEV_W'(div_rem_nx);
						lane_q  <= '0;
						state_q <= ST_LANE_B;
					end
				end

				ST_LANE_B: begin
					lb_q    <= lane_term;
					state_q <= ST_LANE_S;
				end

				ST_LANE_S: begin
					delta_q <= lb_q - lane_term;
					state_q <= ST_LANE_W;
				end

				ST_LANE_W: begin
					cnt_vld_q[lane_q] <= 1'b1;
					lane_q            <= lane_q + DEV_W'(1);
					if (!lane_last)
						state_q <= ST_LANE_B;
					else if ({1'b0, b_q} >= e_q)
						state_q <= ST_OUT;
					else
						state_q <= ST_SEQ_INIT;
				end

				ST_SEQ_INIT: begin
					dev_w_q <= (ni_c < nd_c) ? DEV_W'(ni_c) : nd_last;
					prev_q  <= {1'b0, b_q};
					top_q   <= TOP_W'(lim_q);
					state_q <= ST_SEQ_DEV;
				end

				ST_SEQ_DEV: begin
					if (seq_last) begin
						// last device takes whatever runs past the end
						delta_q <= 32'(e_q - prev_q);
						cidx_q  <= nd_last;
						last_q  <= 1'b1;
						state_q <= ST_CNT_WR;
					end else begin
						state_q <= ST_SEQ_TOP;
					end
				end

				ST_SEQ_TOP: begin
					top_q   <= top_q + TOP_W'(size_rdata);
					state_q <= ST_SEQ_G;
				end

				ST_SEQ_G: begin
					if (top_q <= TOP_W'(b_q)) begin
						g_q     <= {1'b0, b_q};
						state_q <= ST_SEQ_CNT;
					end else if (top_q >= TOP_W'(e_q)) begin
						g_q     <= e_q;
						state_q <= ST_SEQ_CNT;
					end else begin
						div_quo_q <= top_q[DIV_W-1:0];
						div_rem_q <= '0;
						div_dsr_q <= d_c;
						div_cnt_q <= DIVC_W'(DIV_W - 1);
						state_q   <= ST_TOP_DIV;
					end
				end

				ST_TOP_DIV: begin
					if (div_last) begin
						g_q     <= top_g;
						state_q <= ST_SEQ_CNT;
					end
				end

				ST_SEQ_CNT: begin
					delta_q <= 32'(g_q - prev_q);
					prev_q  <= g_q;
					cidx_q  <= dev_w_q;
					last_q  <= 1'b0;
					state_q <= ST_CNT_WR;
				end

				ST_CNT_WR: begin
					cnt_vld_q[cidx_q] <= 1'b1;
					if (last_q) begin
						state_q <= ST_OUT;
					end else begin
						dev_w_q <= dev_w_q + DEV_W'(1);
						state_q <= ST_SEQ_DEV;
					end
				end

				ST_OUT: begin
					if (!result_valid_q || !result_stall) begin
						result_q.device_free <= res_dev_q;
						result_q.total_free  <= free_sum_q;
						result_valid_q       <= 1'b1;
						state_q              <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
